### design/lfsa_pkg.sv
package lfsa_pkg;

    // Default pool size and bitmap word width.
    localparam int LFSA_MAX_SLOTS = 1024;
    localparam int LFSA_WORD_W    = 32;

    // Field widths of the channels and the configuration port.
    localparam int ACTION_W = 2;
    localparam int INDEX_W  = 10;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 11;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    // Action codes.
    localparam logic [ACTION_W-1:0] ACT_ALLOC = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_FREE  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CHECK = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_NOP   = 2'd3;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_TAKEN = 2'd3;

    // Register word index (paddr[2]) of the capacity register.
    localparam logic REG_CAPACITY = 1'b0;

    // Capacity after reset.
    localparam logic [COUNT_W-1:0] CAPACITY_RESET = 11'd1024;

endpackage

### design/lfsa_req_if.sv
interface lfsa_req_if import lfsa_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [INDEX_W-1:0]  slot_index;

    modport source (output valid, output action, output slot_index, input ready);
    modport sink (input valid, input action, input slot_index, output ready);
endinterface

### design/lfsa_rsp_if.sv
interface lfsa_rsp_if import lfsa_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  given_index;
    logic                is_taken;
    logic [COUNT_W-1:0]  high_mark;
    logic [COUNT_W-1:0]  live_count;

    modport source (output valid, output status, output given_index, output is_taken,
                    output high_mark, output live_count, input ready);
    modport sink (input valid, input status, input given_index, input is_taken,
                  input high_mark, input live_count, output ready);
endinterface

### design/lowest_free_slot_allocator_unit.sv
// Channel  Dir  Beat contents
// -------  ---  ---------------------------------------------------------
// req      in   action, slot_index
// rsp      out  status, given_index, is_taken, high_mark, live_count
// apb      in   capacity_in_use register at byte address 0
//
// An accepted item reads its bitmap word and then updates it (a check only
// tests its bit) before the result is loaded. An allocate with no row free, a
// free or check out of range and the no-op code skip the word; a free of the
// top slot then rescans the row summary and one bitmap word for the new top.
// The bitmap is a RAM of 32-bit words with one registered read port; all
// searches go through one shared priority encoder over the summary bits or
// over one word. Reset clears the map at once through per-row valid bits.
// req is ready only while the sequencer is idle; a result still waiting in
// the output register holds the next item in its last step, and req stays
// low until the waiting beat is taken.
module lowest_free_slot_allocator_unit import lfsa_pkg::*; #(
    parameter int MAX_SLOTS = LFSA_MAX_SLOTS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    lfsa_req_if.sink           req,
    lfsa_rsp_if.source         rsp
);

    localparam int WORD_W  = LFSA_WORD_W;
    localparam int BIT_W   = $clog2(WORD_W);
    localparam int ROWS    = (MAX_SLOTS + WORD_W - 1) / WORD_W;
    localparam int ROW_AW  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int SCAN_W  = (ROWS > WORD_W) ? ROWS : WORD_W;
    localparam int SCAN_AW = $clog2(SCAN_W);
    localparam int SLOT_W  = ROW_AW + BIT_W;
    localparam int CNT_W   = $clog2(MAX_SLOTS + 1);
    localparam int CMP_W   = (SLOT_W + 1 > COUNT_W) ? SLOT_W + 1 : COUNT_W;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_READ   = 3'd1;
    localparam logic [2:0] S_TOPROW = 3'd2;
    localparam logic [2:0] S_TOPBIT = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic [ACTION_W-1:0] act_reg, act_next;
    logic [ROW_AW-1:0]   row_reg, row_next;
    logic [BIT_W-1:0]    bit_reg, bit_next;
    logic                rvld_reg, rvld_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [SLOT_W-1:0]   given_reg, given_next;
    logic                taken_reg, taken_next;

    logic [ROWS-1:0]     rowv_reg, rowv_next;
    logic [ROWS-1:0]     full_reg, full_next;
    logic [ROWS-1:0]     nz_reg, nz_next;
    logic [CNT_W-1:0]    live_reg, live_next;
    logic [CNT_W-1:0]    top_reg, top_next;
    logic [COUNT_W-1:0]  cap_reg;

    logic                rsp_vld_reg, rsp_vld_next;
    logic [STATUS_W-1:0] rsp_status_reg;
    logic [INDEX_W-1:0]  rsp_given_reg;
    logic                rsp_taken_reg;
    logic [COUNT_W-1:0]  rsp_high_reg;
    logic [COUNT_W-1:0]  rsp_live_reg;
    logic                rsp_load;

    logic                ram_we;
    logic [ROW_AW-1:0]   ram_raddr;
    logic [WORD_W-1:0]   ram_wdata;
    logic [WORD_W-1:0]   ram_rdata;
    logic [WORD_W-1:0]   word;
    logic [WORD_W-1:0]   bit_mask;
    logic [WORD_W-1:0]   new_word;

    logic [SCAN_W-1:0]   scan_vec;
    logic                scan_from_top;
    logic                scan_found;
    logic [SCAN_AW-1:0]  scan_pos;
    logic [ROW_AW-1:0]   scan_row;
    logic [BIT_W-1:0]    scan_bit;

    logic [CMP_W-1:0]    cap_eff;
    logic [CMP_W-1:0]    idx_cmp;
    logic [SLOT_W-1:0]   slot_in;
    logic                in_range;
    logic [SLOT_W-1:0]   slot_hit;
    logic [CMP_W-1:0]    slot_hit_end;
    logic [CMP_W-1:0]    slot_cur_end;
    logic                accept;

    // Configuration register.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_CAPACITY) ? PDATA_W'(cap_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAPACITY_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY))
        begin
            cap_reg <= pwdata[COUNT_W-1:0];
        end
    end

    // Effective capacity and the incoming index.
    assign cap_eff  = (CMP_W'(cap_reg) > CMP_W'(MAX_SLOTS)) ? CMP_W'(MAX_SLOTS)
                                                            : CMP_W'(cap_reg);
    assign idx_cmp  = CMP_W'(req.slot_index);
    assign slot_in  = SLOT_W'(idx_cmp);
    assign in_range = idx_cmp < cap_eff;

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;

    // Bitmap word store.
    lfsa_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ROWS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (row_reg),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // A row never written reads as all free.
    assign word     = rvld_reg ? ram_rdata : '0;
    assign bit_mask = WORD_W'(1) << bit_reg;

    // Shared search unit, fed according to the sequencer step.
    always_comb
    begin
        scan_vec      = '0;
        scan_from_top = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                scan_vec[ROWS-1:0] = ~full_reg;
            end
            S_READ:
            begin
                scan_vec[WORD_W-1:0] = ~word;
            end
            S_TOPROW:
            begin
                scan_vec[ROWS-1:0] = nz_reg;
                scan_from_top      = 1'b1;
            end
            S_TOPBIT:
            begin
                scan_vec[WORD_W-1:0] = word;
                scan_from_top        = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    lfsa_scan #(
        .SCAN_W (SCAN_W)
    ) u_scan (
        .vec      (scan_vec),
        .from_top (scan_from_top),
        .found    (scan_found),
        .pos      (scan_pos)
    );

    assign scan_row     = ROW_AW'(scan_pos);
    assign scan_bit     = BIT_W'(scan_pos);
    assign slot_hit     = {row_reg, scan_bit};
    assign slot_hit_end = CMP_W'(slot_hit) + CMP_W'(1);
    assign slot_cur_end = CMP_W'({row_reg, bit_reg}) + CMP_W'(1);

    // Sequencer.
    always_comb
    begin
        state_next  = state_reg;
        act_next    = act_reg;
        row_next    = row_reg;
        bit_next    = bit_reg;
        rvld_next   = rvld_reg;
        status_next = status_reg;
        given_next  = given_reg;
        taken_next  = taken_reg;
        rowv_next   = rowv_reg;
        full_next   = full_reg;
        nz_next     = nz_reg;
        live_next   = live_reg;
        top_next    = top_reg;
        ram_we      = 1'b0;
        ram_raddr   = row_reg;
        new_word    = word;
        rsp_load    = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    act_next    = req.action;
                    row_next    = slot_in[SLOT_W-1:BIT_W];
                    bit_next    = slot_in[BIT_W-1:0];
                    status_next = ST_OK;
                    given_next  = '0;
                    taken_next  = 1'b0;
                    case (req.action)
                        ACT_ALLOC:
                        begin
                            if (scan_found)
                            begin
                                row_next   = scan_row;
                                ram_raddr  = scan_row;
                                rvld_next  = rowv_reg[scan_row];
                                state_next = S_READ;
                            end
                            else
                            begin
                                status_next = ST_EMPTY;
                                state_next  = S_DONE;
                            end
                        end
                        ACT_FREE, ACT_CHECK:
                        begin
                            if (in_range)
                            begin
                                ram_raddr  = slot_in[SLOT_W-1:BIT_W];
                                rvld_next  = rowv_reg[slot_in[SLOT_W-1:BIT_W]];
                                state_next = S_READ;
                            end
                            else
                            begin
                                status_next = ST_RANGE;
                                state_next  = S_DONE;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_READ:
            begin
                state_next = S_DONE;
                case (act_reg)
                    ACT_ALLOC:
                    begin
                        if (!scan_found || (CMP_W'(slot_hit) >= cap_eff))
                        begin
                            status_next = ST_EMPTY;
                        end
                        else
                        begin
                            new_word           = word | (WORD_W'(1) << scan_bit);
                            ram_we             = 1'b1;
                            rowv_next[row_reg] = 1'b1;
                            full_next[row_reg] = &new_word;
                            nz_next[row_reg]   = 1'b1;
                            live_next          = live_reg + CNT_W'(1);
                            given_next         = slot_hit;
                            if (slot_hit_end > CMP_W'(top_reg))
                            begin
                                top_next = CNT_W'(slot_hit_end);
                            end
                        end
                    end
                    ACT_FREE:
                    begin
                        if (!word[bit_reg])
                        begin
                            status_next = ST_NOT_TAKEN;
                        end
                        else
                        begin
                            new_word           = word & ~bit_mask;
                            ram_we             = 1'b1;
                            rowv_next[row_reg] = 1'b1;
                            full_next[row_reg] = 1'b0;
                            nz_next[row_reg]   = |new_word;
                            if (live_reg != '0)
                            begin
                                live_next = live_reg - CNT_W'(1);
                            end
                            // Freeing the top slot needs a search for the new top.
                            if (slot_cur_end == CMP_W'(top_reg))
                            begin
                                state_next = S_TOPROW;
                            end
                        end
                    end
                    ACT_CHECK:
                    begin
                        taken_next = word[bit_reg];
                    end
                    default:
                    begin
                    end
                endcase
            end

            S_TOPROW:
            begin
                if (scan_found)
                begin
                    row_next   = scan_row;
                    ram_raddr  = scan_row;
                    rvld_next  = 1'b1;
                    state_next = S_TOPBIT;
                end
                else
                begin
                    top_next   = '0;
                    state_next = S_DONE;
                end
            end

            S_TOPBIT:
            begin
                top_next   = CNT_W'(slot_hit_end);
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!rsp_vld_reg || rsp.ready)
                begin
                    rsp_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign ram_wdata    = new_word;
    assign rsp_vld_next = (rsp_vld_reg && !rsp.ready) || rsp_load;

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            rowv_reg    <= '0;
            full_reg    <= '0;
            nz_reg      <= '0;
            live_reg    <= '0;
            top_reg     <= '0;
            rsp_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rowv_reg    <= rowv_next;
            full_reg    <= full_next;
            nz_reg      <= nz_next;
            live_reg    <= live_next;
            top_reg     <= top_next;
            rsp_vld_reg <= rsp_vld_next;
        end
    end

    // Working registers of the item in progress.
    always_ff @(posedge clk)
    begin
        act_reg    <= act_next;
        row_reg    <= row_next;
        bit_reg    <= bit_next;
        rvld_reg   <= rvld_next;
        status_reg <= status_next;
        given_reg  <= given_next;
        taken_reg  <= taken_next;
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (rsp_load)
        begin
            rsp_status_reg <= status_reg;
            rsp_given_reg  <= INDEX_W'(CMP_W'(given_reg));
            rsp_taken_reg  <= taken_reg;
            rsp_high_reg   <= COUNT_W'(CMP_W'(top_reg));
            rsp_live_reg   <= COUNT_W'(CMP_W'(live_reg));
        end
    end

    assign rsp.valid       = rsp_vld_reg;
    assign rsp.status      = rsp_status_reg;
    assign rsp.given_index = rsp_given_reg;
    assign rsp.is_taken    = rsp_taken_reg;
    assign rsp.high_mark   = rsp_high_reg;
    assign rsp.live_count  = rsp_live_reg;

endmodule

### design/lfsa_ram.sv
module lfsa_ram import lfsa_pkg::*; #(
    parameter int WIDTH = LFSA_WORD_W,
    parameter int DEPTH = LFSA_MAX_SLOTS / LFSA_WORD_W,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### design/lfsa_scan.sv
module lfsa_scan import lfsa_pkg::*; #(
    parameter int SCAN_W = LFSA_WORD_W,
    localparam int POS_W = $clog2(SCAN_W)
) (
    input  logic [SCAN_W-1:0] vec,
    input  logic              from_top,
    output logic              found,
    output logic [POS_W-1:0]  pos
);

    // Priority encoder: position of the lowest or the highest set bit.
    always_comb
    begin
        found = |vec;
        pos   = '0;
        if (from_top)
        begin
            for (int i = 0; i < SCAN_W; i++)
            begin
                if (vec[i])
                begin
                    pos = POS_W'(i);
                end
            end
        end
        else
        begin
            for (int i = SCAN_W - 1; i >= 0; i--)
            begin
                if (vec[i])
                begin
                    pos = POS_W'(i);
                end
            end
        end
    end

endmodule

### sim/lowest_free_slot_allocator_unit_tb.sv
module lowest_free_slot_allocator_unit_tb;
    import lfsa_pkg::*;

    // One request beat and one result beat as the testbench sees them.
    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [INDEX_W-1:0]  slot_index;
    } slot_request_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [INDEX_W-1:0]  given_index;
        logic                is_taken;
        logic [COUNT_W-1:0]  high_mark;
        logic [COUNT_W-1:0]  live_count;
    } slot_reply_t;

    localparam logic [PADDR_W-1:0] CAPACITY_ADDR = {REG_CAPACITY, 2'b00};
    localparam int IDLE_PERCENT    = 37;
    localparam int STALL_LIMIT     = 2000;
    localparam int DRAIN_CYCLES    = 8;
    localparam int RANDOM_PHASES   = 10;
    localparam int ITEMS_PER_PHASE = 112;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    lfsa_req_if req_ch ();
    lfsa_rsp_if rsp_ch ();

    lowest_free_slot_allocator_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .req     (req_ch),
        .rsp     (rsp_ch)
    );

    // Shadow copy of the allocator: bitmap, counts and capacity register.
    logic [LFSA_MAX_SLOTS-1:0] taken_shadow;
    int                        live_shadow;
    int                        top_shadow;
    logic [COUNT_W-1:0]        capacity_shadow;

    slot_request_t pending_requests[$];
    slot_reply_t   predicted_replies[$];

    bit calm_phase;
    int failures;
    int replies_checked;
    int settings_used;
    int status_seen[4];
    int stall_cycles;

    // Free-running clock.
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int effective_capacity();
        return (capacity_shadow > LFSA_MAX_SLOTS) ? LFSA_MAX_SLOTS : int'(capacity_shadow);
    endfunction

    // Apply one request to the shadow allocator and return the result it must give.
    function automatic slot_reply_t apply_request(input slot_request_t rq);
        slot_reply_t r;
        int          cap;
        int          i;
        r = '0;
        cap = effective_capacity();
        case (rq.action)
            ACT_ALLOC:
            begin
                i = 0;
                while (i < cap && taken_shadow[i])
                    i++;
                if (i >= cap)
                    r.status = ST_EMPTY;
                else
                begin
                    taken_shadow[i] = 1'b1;
                    live_shadow++;
                    if (i + 1 > top_shadow)
                        top_shadow = i + 1;
                    r.given_index = i[INDEX_W-1:0];
                end
            end
            ACT_FREE:
            begin
                if (int'(rq.slot_index) >= cap)
                    r.status = ST_RANGE;
                else if (!taken_shadow[rq.slot_index])
                    r.status = ST_NOT_TAKEN;
                else
                begin
                    taken_shadow[rq.slot_index] = 1'b0;
                    if (live_shadow > 0)
                        live_shadow--;
                    // Walk the high mark down past any freed slots.
                    i = top_shadow;
                    while (i > 0 && !taken_shadow[i-1])
                        i--;
                    top_shadow = i;
                end
            end
            ACT_CHECK:
            begin
                if (int'(rq.slot_index) >= cap)
                    r.status = ST_RANGE;
                else
                    r.is_taken = taken_shadow[rq.slot_index];
            end
            default:
            begin
            end
        endcase
        r.high_mark  = top_shadow[COUNT_W-1:0];
        r.live_count = live_shadow[COUNT_W-1:0];
        return r;
    endfunction

    function automatic void compare_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endfunction

    // Request driver: presents queued beats, idling at random between them.
    always @(posedge clk)
    begin
        if (!rst_n)
            req_ch.valid <= 1'b0;
        else
        begin
            if (req_ch.valid && req_ch.ready)
                predicted_replies = {predicted_replies,
                                     apply_request('{req_ch.action, req_ch.slot_index})};
            if (!req_ch.valid || req_ch.ready)
            begin
                if (pending_requests.size() != 0 &&
                    (calm_phase || $urandom_range(99) >= IDLE_PERCENT))
                begin
                    slot_request_t next_beat;
                    next_beat = pending_requests.pop_front();
                    req_ch.valid      <= 1'b1;
                    req_ch.action     <= next_beat.action;
                    req_ch.slot_index <= next_beat.slot_index;
                end
                else
                begin
                    req_ch.valid      <= 1'b0;
                    req_ch.action     <= ACTION_W'($urandom);
                    req_ch.slot_index <= INDEX_W'($urandom);
                end
            end
        end
    end

    // Result monitor: stalls at random and checks each beat against the oldest prediction.
    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (predicted_replies.size() == 0)
                begin
                    $error("result beat arrived with no prediction waiting");
                    failures++;
                end
                else
                begin
                    slot_reply_t want;
                    want = predicted_replies.pop_front();
                    compare_field("status", want.status, rsp_ch.status);
                    compare_field("given_index", want.given_index, rsp_ch.given_index);
                    compare_field("is_taken", want.is_taken, rsp_ch.is_taken);
                    compare_field("high_mark", want.high_mark, rsp_ch.high_mark);
                    compare_field("live_count", want.live_count, rsp_ch.live_count);
                    status_seen[want.status]++;
                    replies_checked++;
                end
            end
            rsp_ch.ready <= calm_phase || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // Watchdog on cycles with no beat moving on any port.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
                (psel && penable && pready))
                stall_cycles <= 0;
            else if (stall_cycles + 1 >= STALL_LIMIT)
            begin
                $display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
                $display("simulation failed");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic queue_request(input logic [ACTION_W-1:0] action,
                                 input logic [INDEX_W-1:0] slot_index);
        pending_requests = {pending_requests, slot_request_t'({action, slot_index})};
    endtask

    // Wait until every queued beat is accepted and every result is back.
    // Sampling on the falling edge sees the driver and monitor updates settled.
    task automatic wait_drained();
        while (pending_requests.size() != 0 || req_ch.valid || predicted_replies.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write the capacity register through the APB port, then read it back.
    task automatic set_capacity(input logic [COUNT_W-1:0] value);
        logic [PDATA_W-1:0] word;
        word = $urandom;
        word[COUNT_W-1:0] = value;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CAPACITY_ADDR;
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        capacity_shadow = value;
        settings_used++;
        @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        compare_field("capacity_in_use readback", value, prdata[COUNT_W-1:0]);
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Random mix; most frees and checks land near the low end where slots are handed out.
    task automatic queue_random_phase(input int count);
        int cap;
        int window;
        int pick;
        logic [INDEX_W-1:0] idx;
        cap = effective_capacity();
        window = (cap < 1) ? 1 : ((cap > 64) ? 64 : cap);
        repeat (count)
        begin
            pick = $urandom_range(99);
            if (pick < 65)
                idx = INDEX_W'($urandom_range(window - 1));
            else if (pick < 85)
                idx = INDEX_W'((cap >= LFSA_MAX_SLOTS) ? $urandom_range(LFSA_MAX_SLOTS - 1)
                                                       : $urandom_range(cap));
            else
                idx = INDEX_W'($urandom);
            pick = $urandom_range(99);
            if (pick < 42)
                queue_request(ACT_ALLOC, INDEX_W'($urandom));
            else if (pick < 72)
                queue_request(ACT_FREE, idx);
            else if (pick < 93)
                queue_request(ACT_CHECK, idx);
            else
                queue_request(ACT_NOP, idx);
        end
    endtask

    initial
    begin
        logic [COUNT_W-1:0] phase_caps[RANDOM_PHASES];
        rst_n   = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        req_ch.valid      = 1'b0;
        req_ch.action     = ACT_NOP;
        req_ch.slot_index = '0;
        rsp_ch.ready      = 1'b0;
        taken_shadow    = '0;
        live_shadow     = 0;
        top_shadow      = 0;
        capacity_shadow = CAPACITY_RESET;
        calm_phase      = 1'b0;
        failures        = 0;
        replies_checked = 0;
        settings_used   = 1;
        stall_cycles    = 0;
        status_seen     = '{default: 0};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Reset capacity: free and check of free slots, grants, top-slot frees, no-op code.
        queue_request(ACT_CHECK, 10'd0);
        queue_request(ACT_FREE, 10'd0);
        queue_request(ACT_ALLOC, 10'd1023);
        queue_request(ACT_ALLOC, 10'd0);
        queue_request(ACT_ALLOC, 10'd0);
        queue_request(ACT_CHECK, 10'd1);
        queue_request(ACT_FREE, 10'd1);
        queue_request(ACT_FREE, 10'd2);
        queue_request(ACT_ALLOC, 10'd0);
        queue_request(ACT_NOP, 10'd1023);
        queue_request(ACT_FREE, 10'd0);
        queue_request(ACT_FREE, 10'd1);
        wait_drained();

        // Small pool: fill it, hit empty, then index out of range.
        set_capacity(11'd4);
        repeat (5) queue_request(ACT_ALLOC, 10'd0);
        queue_request(ACT_FREE, 10'd4);
        queue_request(ACT_FREE, 10'd3);
        queue_request(ACT_ALLOC, 10'd0);
        wait_drained();

        // Capacity lowered below allocated slots: they stay counted but out of reach.
        set_capacity(11'd2);
        queue_request(ACT_FREE, 10'd3);
        queue_request(ACT_ALLOC, 10'd0);
        queue_request(ACT_CHECK, 10'd1);
        wait_drained();

        set_capacity(11'd0);
        queue_request(ACT_ALLOC, 10'd0);
        queue_request(ACT_CHECK, 10'd0);
        wait_drained();

        // Register value above the pool size acts as the full pool.
        set_capacity(11'd2047);
        queue_request(ACT_CHECK, 10'd1023);
        queue_request(ACT_FREE, 10'd3);
        queue_request(ACT_FREE, 10'd2);
        wait_drained();

        // Random phases over a spread of capacities; one runs with no idling at all.
        phase_caps = '{11'd16, 11'd1024, COUNT_W'($urandom_range(100, 1)), 11'd1, 11'd2047,
                       11'd0, 11'd1025, 11'd64, COUNT_W'($urandom_range(2047)), 11'd3};
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            set_capacity(phase_caps[p]);
            calm_phase = (p == 1);
            queue_random_phase(ITEMS_PER_PHASE);
            wait_drained();
        end
        calm_phase = 1'b0;

        if (predicted_replies.size() != 0)
        begin
            $error("%0d predicted results never arrived", predicted_replies.size());
            failures++;
        end
        $display("checked %0d result beats across %0d capacity settings",
                 replies_checked, settings_used);
        $display("status mix: %0d ok, %0d empty, %0d out of range, %0d not allocated",
                 status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_RANGE],
                 status_seen[ST_NOT_TAKEN]);
        if (failures == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### lowest_free_slot_allocator_unit.f
design/lfsa_pkg.sv
design/lfsa_req_if.sv
design/lfsa_rsp_if.sv
design/lfsa_ram.sv
design/lfsa_scan.sv
design/lowest_free_slot_allocator_unit.sv
sim/lowest_free_slot_allocator_unit_tb.sv
